>>> rtl/core/integer_to_decimal_ascii_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the decimal ASCII formatter
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_DECIMAL_ASCII_TOP_MACROS_SVH
`define INTEGER_TO_DECIMAL_ASCII_TOP_MACROS_SVH

// Same-cycle implication.
`define ITDA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("itda: same-cycle check failed");

// Next-cycle implication.
`define ITDA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("itda: next-cycle check failed");

`endif

>>> rtl/core/itda_pkg.sv
// ----------------------------------------------------------------------------
// itda_pkg
// Types and constants shared by the decimal ASCII formatter.
// ----------------------------------------------------------------------------
package itda_pkg;

  localparam int unsigned IN_WIDTH          = 64;
  localparam int unsigned VALUE_WIDTH_DEF   = 64;
  localparam int unsigned CHAR_WIDTH        = 7;

  localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 7'h2D;

  // Double-dabble correction: a digit of 5 or more gets 3 added before the shift.
  localparam logic [3:0] DABBLE_THRESH = 4'd5;
  localparam logic [3:0] DABBLE_ADJ    = 4'd3;

  typedef struct packed {
    logic [IN_WIDTH-1:0] value_bits;
    logic                treat_as_signed;
  } in_req_t;

  typedef struct packed {
    logic [CHAR_WIDTH-1:0] ascii_char;
    logic                  is_last;
  } out_req_t;

  // Per-cycle command to every BCD cell.
  typedef struct packed {
    logic clr;     // zero the digit
    logic dabble;  // correct and shift in one binary bit
    logic shift;   // take the digit of the cell below
  } cell_ctl_t;

endpackage

>>> rtl/core/itda_bcd_cell.sv
// ----------------------------------------------------------------------------
// itda_bcd_cell
// One decimal digit of the double-dabble chain.
// ----------------------------------------------------------------------------
module itda_bcd_cell
  import itda_pkg::*;
(
  input  logic       clk,
  input  cell_ctl_t  ctl,
  input  logic       bit_in,    // binary bit from the cell below
  input  logic [3:0] digit_in,  // digit of the cell below
  output logic       bit_out,   // binary carry to the cell above
  output logic [3:0] digit
);

  logic [3:0] digit_r;
  logic [3:0] adj;

  assign adj     = (digit_r >= DABBLE_THRESH) ? 4'(digit_r + DABBLE_ADJ) : digit_r;
  assign bit_out = adj[3];
  assign digit   = digit_r;

  always_ff @(posedge clk) begin
    priority if (ctl.clr) begin
      digit_r <= '0;
    end else if (ctl.dabble) begin
      digit_r <= {adj[2:0], bit_in};
    end else if (ctl.shift) begin
      digit_r <= digit_in;
    end
  end

endmodule

>>> rtl/core/integer_to_decimal_ascii_top.sv
// ----------------------------------------------------------------------------
// integer_to_decimal_ascii_top
// Binary integer to decimal ASCII string, one character per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carry one request: a raw value (low VALUE_WIDTH
//   bits used) and a signed/unsigned flag. out_valid/out_ready/out_data carry
//   one character per transfer, most significant first, '-' ahead of a
//   negative magnitude, is_last set on the final digit. No leading zeros;
//   zero gives a single '0'.
// Timing:
//   A request is loaded, then double-dabbled through the digit chain (one
//   binary bit a cycle); then leading zeros are shifted away and digits go
//   out one a cycle while out_ready allows, '-' first for a negative value.
//   Unstalled, a request takes the same time whatever its length, set by
//   the bit-serial dabble loop.
//   in_ready is high only when idle; the last character may still sit in the
//   output register while the next request is taken.
// Reset: synchronous, rst_n low returns to idle and drops out_valid.
// Stall: out_ready low holds the output register; emission pauses, nothing
//   is lost or repeated.
// ----------------------------------------------------------------------------
`include "integer_to_decimal_ascii_top_macros.svh"

module integer_to_decimal_ascii_top
  import itda_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output out_req_t out_data
);

  // Decimal digits of 2^VALUE_WIDTH - 1 (log10(2) ~ 0.30103).
  localparam int unsigned NumDigits = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int unsigned BitCntW   = $clog2(VALUE_WIDTH + 1);
  localparam int unsigned DigCntW   = $clog2(NumDigits + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,   // binary bits stream into the chain
    S_SKIP,   // leading zeros shifted away
    S_EMIT    // sign, then digits out
  } state_t;

  state_t               state_r;
  logic [VALUE_WIDTH-1:0] mag_r;
  logic                 neg_r;
  logic [BitCntW-1:0]   bit_cnt_r;
  logic [DigCntW-1:0]   left_r;     // digits still in the chain
  logic                 out_valid_r;
  out_req_t             out_data_r;

  logic [VALUE_WIDTH-1:0] value_w;
  logic                 neg_in;
  logic [VALUE_WIDTH-1:0] mag_in;
  logic                 slot_free;
  logic                 emit_now;   // a character is loaded this cycle
  logic                 last_emit;  // ... and it is the final digit
  logic                 char_ok;
  logic [3:0]           top_digit;
  cell_ctl_t            ctl;

  logic [NumDigits:0]   carry;            // binary carry between cells
  logic [3:0]           digits [NumDigits];

  // Magnitude: two's-complement negate is exact for the most negative value.
  assign value_w = in_data.value_bits[VALUE_WIDTH-1:0];
  assign neg_in  = in_data.treat_as_signed & value_w[VALUE_WIDTH-1];
  assign mag_in  = neg_in ? (~value_w + 1'b1) : value_w;

  assign slot_free = !out_valid_r || out_ready;
  assign emit_now  = (state_r == S_EMIT) && slot_free;
  assign last_emit = emit_now && !neg_r && (left_r == DigCntW'(1));
  assign top_digit = digits[NumDigits-1];
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign char_ok = (out_data_r.ascii_char == CHAR_MINUS) ||
                   ((out_data_r.ascii_char >= CHAR_ZERO) &&
                    (out_data_r.ascii_char <= CHAR_ZERO + 7'd9));

  // Cell command
  always_comb begin
    ctl = '0;
    unique case (state_r)
      S_IDLE: ctl.clr    = in_valid;
      S_CONV: ctl.dabble = 1'b1;
      S_SKIP: ctl.shift  = (top_digit == 4'd0) && (left_r > DigCntW'(1));
      S_EMIT: ctl.shift  = !neg_r && slot_free;
      default: ctl = '0;
    endcase
  end

  // Digit chain: cell 0 takes the magnitude MSB first; digits move upward on skip and emit.
  assign carry[0] = mag_r[VALUE_WIDTH-1];

  for (genvar i = 0; i < NumDigits; i++) begin : g_cell
    logic [3:0] below;
    if (i == 0) begin : g_bottom
      assign below = 4'd0;
    end else begin : g_upper
      assign below = digits[i-1];
    end
    itda_bcd_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .bit_in   (carry[i]),
      .digit_in (below),
      .bit_out  (carry[i+1]),
      .digit    (digits[i])
    );
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // Loaded when a character is issued, cleared once taken.
      out_valid_r <= emit_now || (out_valid_r && !out_ready);
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            mag_r     <= mag_in;
            neg_r     <= neg_in;
            bit_cnt_r <= BitCntW'(VALUE_WIDTH);
            state_r   <= S_CONV;
          end
        end
        S_CONV: begin
          mag_r     <= mag_r << 1;
          bit_cnt_r <= bit_cnt_r - 1'b1;
          if (bit_cnt_r == BitCntW'(1)) begin
            left_r  <= DigCntW'(NumDigits);
            state_r <= S_SKIP;
          end
        end
        S_SKIP: begin
          if ((top_digit == 4'd0) && (left_r > DigCntW'(1))) begin
            left_r <= left_r - 1'b1;
          end else begin
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            if (neg_r) begin
              out_data_r.ascii_char <= CHAR_MINUS;
              out_data_r.is_last    <= 1'b0;
              neg_r                 <= 1'b0;
            end else begin
              out_data_r.ascii_char <= CHAR_ZERO + CHAR_WIDTH'(top_digit);
              out_data_r.is_last    <= (left_r == DigCntW'(1));
              left_r                <= left_r - 1'b1;
              if (left_r == DigCntW'(1)) begin
                state_r <= S_IDLE;
              end
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // The top digit never carries out while dabbling: the chain is wide enough.
  `ITDA_ASSERT_IMP(a_no_bcd_overflow, state_r == S_CONV, !carry[NumDigits])

  // Only '-' or a decimal digit ever leaves the block.
  `ITDA_ASSERT_IMP(a_legal_char, out_valid_r, char_ok)

  // A new request is taken only once the previous string has been fully issued.
  `ITDA_ASSERT_IMP(a_ready_after_last, in_ready && out_valid_r, out_data_r.is_last)

  // The sign character always comes with more digits to follow.
  `ITDA_ASSERT_IMP(a_sign_not_last, out_valid_r && (out_data_r.ascii_char == CHAR_MINUS), !out_data_r.is_last)

  // The last digit returns the sequencer to idle.
  `ITDA_ASSERT_NXT(a_last_to_idle, last_emit, state_r == S_IDLE)

endmodule
